/* sv/pidw_pkg.sv */
package pidw_pkg;

	// field widths
	localparam int IN_W      = 16;
	localparam int ERR_W     = 17;
	localparam int DRIVE_W   = 24;
	localparam int GAIN_W    = 24;
	localparam int LIMIT_W   = 23;
	localparam int GAIN_FRAC = 12;

	// datapath widths
	localparam int SUM3_W   = ERR_W + 2;
	localparam int DIFF_W   = ERR_W + 1;
	localparam int PROD_P_W = GAIN_W + ERR_W;
	localparam int PROD_I_W = GAIN_W + SUM3_W;
	localparam int PROD_D_W = GAIN_W + DIFF_W;
	localparam int ACC_W    = PROD_I_W + 1;
	localparam int SCALED_W = ACC_W - GAIN_FRAC;

	// register port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register reset values
	localparam logic signed [GAIN_W-1:0] KP_RESET         = 24'sd8192;
	localparam logic signed [GAIN_W-1:0] KI_DT_RESET      = 24'sd0;
	localparam logic signed [GAIN_W-1:0] KD_OVER_DT_RESET = 24'sd8192;
	localparam int                       LIMIT_RESET_UNITS = 200;

	typedef enum logic [1:0] {
		REG_KP         = 2'd0,
		REG_KI_DT      = 2'd1,
		REG_KD_OVER_DT = 2'd2,
		REG_LIMIT      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki_dt;
		logic signed [GAIN_W-1:0] kd_over_dt;
		logic [LIMIT_W-1:0]       limit;
	} gains_t;

endpackage

/* sv/pidw_regs.sv */
module pidw_regs import pidw_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output gains_t                gains
);

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(LIMIT_RESET_UNITS << FRAC_BITS);

	gains_t   gains_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign pready = 1'b1;
	assign gains  = gains_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp         <= KP_RESET;
			gains_q.ki_dt      <= KI_DT_RESET;
			gains_q.kd_over_dt <= KD_OVER_DT_RESET;
			gains_q.limit      <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (idx)
				REG_KP:         gains_q.kp         <= pwdata[GAIN_W-1:0];
				REG_KI_DT:      gains_q.ki_dt      <= pwdata[GAIN_W-1:0];
				REG_KD_OVER_DT: gains_q.kd_over_dt <= pwdata[GAIN_W-1:0];
				REG_LIMIT:      gains_q.limit      <= pwdata[LIMIT_W-1:0];
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_KP:         prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gains_q.kp};
			REG_KI_DT:      prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gains_q.ki_dt};
			REG_KD_OVER_DT: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gains_q.kd_over_dt};
			REG_LIMIT:      prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, gains_q.limit};
		endcase
	end

endmodule

/* sv/pid_axis_with_window_integral.sv */
// One axis of a discrete PID regulator with a three-tap error window as integral.
//
// sample channel (sample_valid/sample_ready, goal, measured): one control tick per
// transaction. result channel (result_valid/result_ready, drive, error, clamped):
// one result per sample, in order. The gains and the clamp limit sit on the
// APB-style register port (kp, ki_dt, kd_over_dt, limit at byte 0, 4, 8, 12);
// write them only while no sample is in flight.
//
// From sample acceptance to result_valid, an input stage forms the error and the
// window sum/difference, a multiply stage forms the three gain products and an
// output stage adds, rounds and clamps. Throughput is one sample per cycle while
// result_ready is high. Each stage has its own valid bit and moves when the stage
// after it is empty or moving, so when the receiver stalls the result holds and
// the pipe still takes up to two more samples before sample_ready drops.
// Reset empties the pipe, clears the two stored errors and loads the register
// reset values (limit is 200 in value format).
module pid_axis_with_window_integral import pidw_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [APB_ADDR_W-1:0]      paddr,
	input  logic [APB_DATA_W-1:0]      pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [IN_W-1:0]     goal,
	input  logic signed [IN_W-1:0]     measured,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [DRIVE_W-1:0]  drive,
	output logic signed [ERR_W-1:0]    error,
	output logic                       clamped
);

	gains_t gains;

	pidw_regs #(
		.FRAC_BITS (FRAC_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.gains   (gains)
	);

	// stage enables
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3, take;

	assign en3          = !valid_s3 || result_ready;
	assign en2          = !valid_s2 || en3;
	assign en1          = !valid_s1 || en2;
	assign sample_ready = en1;
	assign take         = sample_valid && sample_ready;

	// error window
	logic signed [ERR_W-1:0]  err_prev1_q, err_prev2_q, err_next;
	logic signed [SUM3_W-1:0] sum3_next;
	logic signed [DIFF_W-1:0] diff_next;

	assign err_next  = ERR_W'(goal) - ERR_W'(measured);
	assign sum3_next = SUM3_W'(err_next) + SUM3_W'(err_prev1_q) + SUM3_W'(err_prev2_q);
	assign diff_next = DIFF_W'(err_next) - DIFF_W'(err_prev1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_prev1_q <= '0;
			err_prev2_q <= '0;
		end else if (take) begin
			err_prev1_q <= err_next;
			err_prev2_q <= err_prev1_q;
		end
	end

	// stage 1: error terms
	logic signed [ERR_W-1:0]  error_s1;
	logic signed [SUM3_W-1:0] sum3_s1;
	logic signed [DIFF_W-1:0] diff_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			error_s1 <= err_next;
			sum3_s1  <= sum3_next;
			diff_s1  <= diff_next;
		end
	end

	// stage 2: gain products
	logic signed [ERR_W-1:0]    error_s2;
	logic signed [PROD_P_W-1:0] prod_p_s2;
	logic signed [PROD_I_W-1:0] prod_i_s2;
	logic signed [PROD_D_W-1:0] prod_d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			error_s2  <= error_s1;
			prod_p_s2 <= PROD_P_W'(gains.kp) * PROD_P_W'(error_s1);
			prod_i_s2 <= PROD_I_W'(gains.ki_dt) * PROD_I_W'(sum3_s1);
			prod_d_s2 <= PROD_D_W'(gains.kd_over_dt) * PROD_D_W'(diff_s1);
		end
	end

	// stage 3: sum, round half up, clamp
	logic signed [ACC_W-1:0]    acc;
	logic signed [SCALED_W-1:0] scaled, lim_pos, lim_neg;
	logic signed [DRIVE_W-1:0]  drive_next;
	logic                       hit_next;

	assign acc     = ACC_W'(prod_p_s2) + ACC_W'(prod_i_s2) + ACC_W'(prod_d_s2)
	               + ACC_W'(1 << (GAIN_FRAC - 1));
	assign scaled  = acc[ACC_W-1:GAIN_FRAC];
	assign lim_pos = $signed({{(SCALED_W-LIMIT_W){1'b0}}, gains.limit});
	assign lim_neg = -lim_pos;

	always_comb begin
		if (scaled > lim_pos) begin
			drive_next = DRIVE_W'(lim_pos);
			hit_next   = 1'b1;
		end else if (scaled < lim_neg) begin
			drive_next = DRIVE_W'(lim_neg);
			hit_next   = 1'b1;
		end else begin
			drive_next = DRIVE_W'(scaled);
			hit_next   = 1'b0;
		end
	end

	logic signed [DRIVE_W-1:0] drive_s3;
	logic signed [ERR_W-1:0]   error_s3;
	logic                      clamped_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			drive_s3   <= drive_next;
			error_s3   <= error_s2;
			clamped_s3 <= hit_next;
		end
	end

	assign result_valid = valid_s3;
	assign drive        = drive_s3;
	assign error        = error_s3;
	assign clamped      = clamped_s3;

`ifndef SYNTHESIS
	logic signed [DRIVE_W-1:0] lim_drive;
	assign lim_drive = $signed({{(DRIVE_W-LIMIT_W){1'b0}}, gains.limit});

	// a clamped result sits exactly on a bound
	a_clamp_on_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && clamped) |-> (drive == lim_drive || drive == -lim_drive))
		else $error("clamped drive not on a bound");

	// an unclamped result stays inside the bounds
	a_inside_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !clamped) |-> (drive <= lim_drive && drive >= -lim_drive))
		else $error("unclamped drive outside bounds");

	// the error window shifts on each accepted sample
	a_window_shift: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (err_prev1_q == $past(err_next) && err_prev2_q == $past(err_prev1_q)))
		else $error("error window did not shift");

	// a full pipe under stall refuses samples
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && !result_ready) |-> !sample_ready)
		else $error("sample taken while pipe full and stalled");
`endif

endmodule

/* dv/pidw_checker.sv */
`timescale 1ns / 1ps

module pidw_checker import pidw_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [APB_ADDR_W-1:0]     paddr,
	input  logic [APB_DATA_W-1:0]     pwdata,
	input  logic                      pready,
	input  logic                      sample_valid,
	input  logic                      sample_ready,
	input  logic signed [IN_W-1:0]    goal,
	input  logic signed [IN_W-1:0]    measured,
	input  logic                      result_valid,
	input  logic                      result_ready,
	input  logic signed [DRIVE_W-1:0] drive,
	input  logic signed [ERR_W-1:0]   error,
	input  logic                      clamped,
	output int                        mismatches,
	output int                        pending
);

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   error;
		logic                      clamped;
	} tick_out_t;

	// shadow copy of the gain registers and the error window
	logic signed [GAIN_W-1:0] kp_q;
	logic signed [GAIN_W-1:0] ki_q;
	logic signed [GAIN_W-1:0] kd_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic signed [ERR_W-1:0]  err_last;
	logic signed [ERR_W-1:0]  err_older;

	tick_out_t tick_expect_q[$];
	tick_out_t want;
	tick_out_t got;

	// one control tick: three gain products, round off the gain fraction, clamp
	function automatic tick_out_t compute_tick(input logic signed [IN_W-1:0] g,
		input logic signed [IN_W-1:0] m);
		longint    e;
		longint    acc;
		longint    q;
		longint    lim;
		tick_out_t r;
		e   = longint'(g) - longint'(m);
		acc = longint'(kp_q) * e
			+ longint'(ki_q) * (e + longint'(err_last) + longint'(err_older))
			+ longint'(kd_q) * (e - longint'(err_last));
		q   = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
		lim = longint'(limit_q);
		r.clamped = 1'b0;
		if (q > lim) begin
			q = lim;
			r.clamped = 1'b1;
		end else if (q < -lim) begin
			q = -lim;
			r.clamped = 1'b1;
		end
		r.drive = q[DRIVE_W-1:0];
		r.error = e[ERR_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       = KP_RESET;
			ki_q       = KI_DT_RESET;
			kd_q       = KD_OVER_DT_RESET;
			limit_q    = LIMIT_W'(LIMIT_RESET_UNITS << FRAC_BITS);
			err_last   = '0;
			err_older  = '0;
			tick_expect_q.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			// register writes seen on the APB port
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
					REG_KP:         kp_q = pwdata[GAIN_W-1:0];
					REG_KI_DT:      ki_q = pwdata[GAIN_W-1:0];
					REG_KD_OVER_DT: kd_q = pwdata[GAIN_W-1:0];
					REG_LIMIT:      limit_q = pwdata[LIMIT_W-1:0];
				endcase
			end

			// result transaction against the oldest expected tick
			if (result_valid && result_ready) begin
				got.drive   = drive;
				got.error   = error;
				got.clamped = clamped;
				if (tick_expect_q.size() == 0) begin
					$display("%0t pid check: unexpected result drive %0d error %0d clamped %0b",
						$time, got.drive, got.error, got.clamped);
					mismatches++;
				end else begin
					want = tick_expect_q.pop_front();
					if (got.drive !== want.drive) begin
						$display("%0t pid check: drive expected %0d actual %0d",
							$time, want.drive, got.drive);
						mismatches++;
					end
					if (got.error !== want.error) begin
						$display("%0t pid check: error expected %0d actual %0d",
							$time, want.error, got.error);
						mismatches++;
					end
					if (got.clamped !== want.clamped) begin
						$display("%0t pid check: clamped expected %0b actual %0b",
							$time, want.clamped, got.clamped);
						mismatches++;
					end
				end
			end

			// sample transaction: predict, then shift the error window
			if (sample_valid && sample_ready) begin
				want = compute_tick(goal, measured);
				tick_expect_q.push_back(want);
				err_older = err_last;
				err_last  = want.error;
			end

			pending = tick_expect_q.size();
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import pidw_pkg::*;

	localparam int FRAC_BITS       = 8;
	localparam int CYCLE_LIMIT     = 1000000;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int GAIN_MIN        = -8388608;
	localparam int GAIN_MAX        = 8388607;
	localparam int LIMIT_MAX       = 8388607;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [APB_ADDR_W-1:0]     paddr = '0;
	logic [APB_DATA_W-1:0]     pwdata = '0;
	logic [APB_DATA_W-1:0]     prdata;
	logic                      pready;
	logic                      sample_valid = 1'b0;
	logic                      sample_ready;
	logic signed [IN_W-1:0]    goal = '0;
	logic signed [IN_W-1:0]    measured = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic signed [ERR_W-1:0]   error;
	logic                      clamped;

	int   mismatches;
	int   pending;
	int   cycle_count = 0;
	logic steady = 1'b0;

	always #6 clk = ~clk;

	pid_axis_with_window_integral #(
		.FRAC_BITS(FRAC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.goal(goal),
		.measured(measured),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.drive(drive),
		.error(error),
		.clamped(clamped)
	);

	pidw_checker #(
		.FRAC_BITS(FRAC_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.goal(goal),
		.measured(measured),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.drive(drive),
		.error(error),
		.clamped(clamped),
		.mismatches(mismatches),
		.pending(pending)
	);

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result back-pressure in random bursts
	initial begin : result_stall
		int n;
		@(posedge arst_n);
		forever begin
			if (!steady && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 17);
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			n = $urandom_range(1, 17);
			result_ready <= 1'b1;
			repeat (n) @(posedge clk);
		end
	end

	// one sample transaction, with an optional idle burst ahead of it
	task automatic send_sample(input int g, input int m);
		int n;
		if (!steady && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 17);
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		sample_valid <= 1'b1;
		goal         <= IN_W'(g);
		measured     <= IN_W'(m);
		do @(posedge clk); while (!sample_ready);
	endtask

	// stop sending and wait for every expected result
	task automatic drain_results();
		sample_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// new gains only with the pipe empty; unused upper data bits are random
	task automatic load_gains(input int kp, input int ki, input int kd, input int lim);
		drain_results();
		@(posedge clk);
		write_reg(REG_KP, {8'($urandom), 24'(kp)});
		write_reg(REG_KI_DT, {8'($urandom), 24'(ki)});
		write_reg(REG_KD_OVER_DT, {8'($urandom), 24'(kd)});
		write_reg(REG_LIMIT, {9'($urandom), 23'(lim)});
	endtask

	function automatic int pick_gain();
		int pool[5] = '{GAIN_MIN, GAIN_MAX, 0, 1, -1};
		case ($urandom_range(0, 3))
			0:       return int'($urandom_range(0, 16777215)) + GAIN_MIN;
			1:       return pool[$urandom_range(0, 4)];
			default: return int'($urandom_range(0, 16384)) - 8192;
		endcase
	endfunction

	initial begin : stimulus
		int g;
		int m;
		int lim;
		int sel;
		int rail_vals[4] = '{-32768, 32767, 0, -1};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gains: full-scale errors clamp both ways
		send_sample(0, 0);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(32767, 32767);
		send_sample(-32768, -32768);

		// one lsb of gain: ties round toward plus infinity
		load_gains(1, 0, 0, LIMIT_MAX);
		send_sample(2048, 0);
		send_sample(0, 2048);
		send_sample(2047, 0);
		send_sample(-2049, 0);
		send_sample(6144, 0);

		// unity gain against the clamp bounds
		load_gains(4096, 0, 0, 100);
		send_sample(100, 0);
		send_sample(101, 0);
		send_sample(-100, 0);
		send_sample(-101, 0);

		// zero limit
		load_gains(4096, 0, 0, 0);
		send_sample(5, 5);
		send_sample(1, 0);
		send_sample(0, 1);

		// extreme gains with the whole error window in play
		load_gains(GAIN_MIN, GAIN_MAX, GAIN_MIN, LIMIT_MAX);
		send_sample(32767, -32768);
		send_sample(-32768, 32767);
		send_sample(32767, -32768);

		// random gain settings, last phase with no idling
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 5))
				0:       lim = 0;
				1:       lim = LIMIT_MAX;
				2:       lim = $urandom_range(0, LIMIT_MAX);
				default: lim = $urandom_range(0, 4096);
			endcase
			load_gains(pick_gain(), pick_gain(), pick_gain(), lim);
			steady = (p == RANDOM_PHASES - 1) || ($urandom_range(0, 4) == 0);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				sel = $urandom_range(0, 9);
				if (sel < 4) begin
					g = int'($urandom_range(0, 65535)) - 32768;
					m = int'($urandom_range(0, 65535)) - 32768;
				end else if (sel < 9) begin
					// settling loop: measured close to goal
					g = int'($urandom_range(0, 65535)) - 32768;
					m = g + int'($urandom_range(0, 64)) - 32;
					if (m > 32767)
						m = 32767;
					if (m < -32768)
						m = -32768;
				end else begin
					g = rail_vals[$urandom_range(0, 3)];
					m = rail_vals[$urandom_range(0, 3)];
				end
				send_sample(g, m);
			end
		end

		// drain and let the pipe settle
		drain_results();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

/* files.f */
sv/pidw_pkg.sv
sv/pidw_regs.sv
sv/pid_axis_with_window_integral.sv
dv/pidw_checker.sv
dv/tb_top.sv
